@@ hdl/rtd_pkg.sv @@
// Shared widths, constants and register codes for the RTD temperature converter.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none
package rtd_pkg;

    localparam int RAW_W       = 24;
    localparam int CODE_W      = 22;
    localparam int MAG_W       = 21;
    localparam int TEMP_W      = 16;
    localparam int RES_W       = 16;
    localparam int NUM_W       = 37;
    localparam int FEED_W      = 8;
    localparam int SIDE_W      = CODE_W + 2;
    localparam int FRACTION_BITS_DEF = 24;

    localparam logic [RES_W-1:0]  REF_RESET  = 16'd1000;
    localparam logic [RES_W-1:0]  NOM_RESET  = 16'd100;
    localparam logic [CODE_W-1:0] FULL_SCALE = 22'h200000;
    localparam logic [TEMP_W-1:0] TEMP_MAX   = 16'hFFFF;
    localparam logic [7:0]        SAT_INT    = 8'd129;

    typedef logic [RES_W-1:0] res_t;
    typedef logic [NUM_W-1:0] num_t;

    typedef enum logic [0:0] {
        REG_REF = 1'b0,
        REG_NOM = 1'b1
    } cfg_reg_t;

endpackage
`default_nettype wire

@@ hdl/rtd_if.sv @@
// Stream interfaces for ADC words in and temperature results out.
// Depends on rtd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rtd_in_if;
    import rtd_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_word;
    modport source (output valid, output raw_word, input ready);
    modport sink   (input valid, input raw_word, output ready);
endinterface

interface rtd_out_if;
    import rtd_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code;
    logic              overflow;
    logic              range_error;
    logic [TEMP_W-1:0] temperature;
    modport source (output valid, output code, output overflow, output range_error,
                    output temperature, input ready);
    modport sink   (input valid, input code, input overflow, input range_error,
                    input temperature, output ready);
endinterface
`default_nettype wire

@@ hdl/rtd_div_cell.sv @@
// One restoring-division cell: one quotient bit per request per stage.
// Depends on rtd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtd_div_cell #(
    parameter int QW = 32,
    parameter int SW = 25
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire rtd_pkg::num_t            rem_i,
    input  wire logic [rtd_pkg::FEED_W-1:0] feed_i,
    input  wire logic [QW-1:0]            q_i,
    input  wire rtd_pkg::num_t            div_i,
    input  wire logic [SW-1:0]            side_i,
    output rtd_pkg::num_t                 rem_o,
    output logic [rtd_pkg::FEED_W-1:0]    feed_o,
    output logic [QW-1:0]                 q_o,
    output rtd_pkg::num_t                 div_o,
    output logic [SW-1:0]                 side_o
);
    import rtd_pkg::*;

    logic [NUM_W:0]  trial;
    logic            ge;
    num_t            rem_next;
    num_t            rem_reg;
    logic [FEED_W-1:0] feed_reg;
    logic [QW-1:0]   q_reg;
    num_t            div_reg;
    logic [SW-1:0]   side_reg;

    always_comb
    begin
        trial    = {rem_i, feed_i[FEED_W-1]};
        ge       = trial >= {1'b0, div_i};
        rem_next = ge ? NUM_W'(trial - {1'b0, div_i}) : NUM_W'(trial);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            feed_reg <= {feed_i[FEED_W-2:0], 1'b0};
            q_reg    <= {q_i[QW-2:0], ge};
            div_reg  <= div_i;
            side_reg <= side_i;
        end
    end

    assign rem_o  = rem_reg;
    assign feed_o = feed_reg;
    assign q_o    = q_reg;
    assign div_o  = div_reg;
    assign side_o = side_reg;

endmodule
`default_nettype wire

@@ hdl/rtd_mul.sv @@
// Three-stage signed fixed-point multiply-add: r = addend + trunc0(a*b >> F).
// Four partial products; depends on rtd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtd_mul #(
    parameter int F  = 24,
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int WR = 32,
    parameter int WS = 24
) (
    input  wire logic                  clk,
    input  wire logic [2:0]            en,
    input  wire logic signed [WA-1:0]  a,
    input  wire logic signed [WB-1:0]  b,
    input  wire logic signed [WR-1:0]  addend,
    input  wire logic [WS-1:0]         side_i,
    output logic signed [WR-1:0]       r,
    output logic [WS-1:0]              side_o
);
    import rtd_pkg::*;

    localparam int HA = (WA + 1) / 2;
    localparam int LA = WA - HA;
    localparam int HB = (WB + 1) / 2;
    localparam int LB = WB - HB;
    localparam int WP = WA + WB;

    logic [WA-1:0]        ua_reg;
    logic [WB-1:0]        ub_reg;
    logic                 neg0_reg, neg1_reg;
    logic signed [WR-1:0] add0_reg, add1_reg;
    logic [WS-1:0]        side0_reg, side1_reg, side2_reg;
    logic [HA+HB-1:0]     pp00_reg;
    logic [HA+LB-1:0]     pp01_reg;
    logic [LA+HB-1:0]     pp10_reg;
    logic [LA+LB-1:0]     pp11_reg;
    logic signed [WR-1:0] r_reg;
    logic signed [WR-1:0] r_next;
    logic [WP-1:0]        prod;
    logic [WP-1:0]        shifted;
    logic [WR-1:0]        mag;
    logic [WR-1:0]        smag;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ua_reg    <= a[WA-1] ? WA'(-a) : WA'(a);
            ub_reg    <= b[WB-1] ? WB'(-b) : WB'(b);
            neg0_reg  <= a[WA-1] ^ b[WB-1];
            add0_reg  <= addend;
            side0_reg <= side_i;
        end
        if (en[1])
        begin
            pp00_reg  <= ua_reg[HA-1:0]  * ub_reg[HB-1:0];
            pp01_reg  <= ua_reg[HA-1:0]  * ub_reg[WB-1:HB];
            pp10_reg  <= ua_reg[WA-1:HA] * ub_reg[HB-1:0];
            pp11_reg  <= ua_reg[WA-1:HA] * ub_reg[WB-1:HB];
            neg1_reg  <= neg0_reg;
            add1_reg  <= add0_reg;
            side1_reg <= side0_reg;
        end
        if (en[2])
        begin
            r_reg     <= r_next;
            side2_reg <= side1_reg;
        end
    end

    always_comb
    begin
        prod = WP'(pp00_reg) + (WP'(pp01_reg) << HB) + (WP'(pp10_reg) << HA)
             + (WP'(pp11_reg) << (HA + HB));
        shifted = prod >> F;
        mag     = shifted[WR-1:0];
        smag    = neg1_reg ? (~mag + WR'(1)) : mag;
        r_next  = add1_reg + signed'(smag);
    end

    assign r      = r_reg;
    assign side_o = side2_reg;

endmodule
`default_nettype wire

@@ hdl/adc_code_to_rtd_temperature.sv @@
// RTD temperature from a 24-bit ratiometric ADC word. Takes one word per clock while
// the result side is not stalled and returns one result per word, in order; the row of
// division cells produces one quotient bit per cell.
// Stalls on the result side hold only the stages that are full; bubbles close up.
// Depends on rtd_pkg, rtd_if, rtd_div_cell and rtd_mul.
`timescale 1ns / 1ps
`default_nettype none
module adc_code_to_rtd_temperature #(
    parameter int FRACTION_BITS = rtd_pkg::FRACTION_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire rtd_pkg::cfg_reg_t cfg_index,
    input  wire rtd_pkg::res_t     cfg_data,
    rtd_in_if.sink                 sample_in,
    rtd_out_if.source              result_out
);
    import rtd_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int QW     = F + 8;
    localparam int WX     = F + 8;
    localparam int WC     = F + 1;
    localparam int WI     = F + 8;
    localparam int WM     = F + 15;
    localparam int WT     = F + 22;
    localparam int D      = QW;
    localparam int S_DIV0 = 3;
    localparam int S_X    = S_DIV0 + D;
    localparam int S_M1   = S_X + 1;
    localparam int S_M2   = S_M1 + 3;
    localparam int S_M3   = S_M2 + 3;
    localparam int S_OUT  = S_M3 + 3;
    localparam int NS     = S_OUT + 1;
    localparam int DSW    = SIDE_W + 1;

    localparam logic [63:0] COEF_A64 = ((64'd2558723 << F) + 64'd5000) / 64'd10000;
    localparam logic [63:0] COEF_B64 = ((64'd96 << F) + 64'd5) / 64'd10;
    localparam logic [63:0] COEF_C64 = ((64'd878 << F) + 64'd500) / 64'd1000;
    localparam logic signed [WM-1:0] COEF_A = WM'(COEF_A64);
    localparam logic signed [WI-1:0] COEF_B = WI'(COEF_B64);
    localparam logic signed [WC-1:0] COEF_C = WC'(COEF_C64);
    localparam logic [QW:0]          ONE_Q  = (QW+1)'(1) << F;
    localparam logic signed [WX-1:0] X_MAX  = {1'b0, {(WX-1){1'b1}}};

    res_t ref_reg, nom_reg;
    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= REF_RESET;
            nom_reg <= NOM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REF: ref_reg <= cfg_data;
                REG_NOM: nom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain, bubbles collapse
    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || result_out.ready;
        for (int k = NS - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= sample_in.valid;
            for (int k = 1; k < NS; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    assign sample_in.ready = adv[0];

    // stage 0: decode
    logic [CODE_W-1:0] code_reg;
    logic              ovf_reg, rng_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic              dbl;
    logic [CODE_W-1:0] code_next;

    always_comb
    begin
        dbl       = sample_in.raw_word[RAW_W-1] && sample_in.raw_word[RAW_W-2];
        code_next = dbl ? CODE_W'(1) : sample_in.raw_word[CODE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            code_reg <= code_next;
            ovf_reg  <= dbl;
            rng_reg  <= code_next[CODE_W-1];
            mag_reg  <= code_next[CODE_W-1] ? '0 : code_next[MAG_W-1:0];
        end
    end

    // stage 1: numerator and denominator products
    num_t              num_reg, den_reg;
    logic [SIDE_W-1:0] side1_reg;
    res_t              nom_eff;

    assign nom_eff = (nom_reg == '0) ? RES_W'(1) : nom_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            num_reg   <= NUM_W'(ref_reg) * NUM_W'(mag_reg);
            den_reg   <= NUM_W'(FULL_SCALE - {1'b0, mag_reg}) * NUM_W'(nom_eff);
            side1_reg <= {code_reg, ovf_reg, rng_reg};
        end
    end

    // stage 2: saturation test and divider seed
    num_t              rem0_reg, div0_reg;
    logic [FEED_W-1:0] feed0_reg;
    logic [DSW-1:0]    dside0_reg;
    logic [NUM_W+7:0]  den129;

    assign den129 = (NUM_W+8)'({den_reg, 7'b0}) + (NUM_W+8)'(den_reg);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            rem0_reg   <= num_reg >> FEED_W;
            feed0_reg  <= num_reg[FEED_W-1:0];
            div0_reg   <= den_reg;
            dside0_reg <= {side1_reg, ({8'b0, num_reg} >= den129)};
        end
    end

    // division cells
    num_t              rem_a  [0:D];
    num_t              div_a  [0:D];
    logic [FEED_W-1:0] feed_a [0:D];
    logic [QW-1:0]     q_a    [0:D];
    logic [DSW-1:0]    dside_a[0:D];

    assign rem_a[0]   = rem0_reg;
    assign div_a[0]   = div0_reg;
    assign feed_a[0]  = feed0_reg;
    assign q_a[0]     = '0;
    assign dside_a[0] = dside0_reg;

    for (genvar g = 0; g < D; g++)
    begin : g_div
        rtd_div_cell #(
            .QW (QW),
            .SW (DSW)
        ) u_cell (
            .clk    (clk),
            .en     (adv[S_DIV0+g]),
            .rem_i  (rem_a[g]),
            .feed_i (feed_a[g]),
            .q_i    (q_a[g]),
            .div_i  (div_a[g]),
            .side_i (dside_a[g]),
            .rem_o  (rem_a[g+1]),
            .feed_o (feed_a[g+1]),
            .q_o    (q_a[g+1]),
            .div_o  (div_a[g+1]),
            .side_o (dside_a[g+1])
        );
    end

    // x = ratio - 1
    logic signed [WX-1:0] x_reg;
    logic [SIDE_W-1:0]    sidex_reg;
    logic [QW:0]          xdiff;

    assign xdiff = {1'b0, q_a[D]} - ONE_Q;

    always_ff @(posedge clk)
    begin
        if (adv[S_X])
        begin
            x_reg     <= dside_a[D][0] ? X_MAX : signed'(xdiff[WX-1:0]);
            sidex_reg <= dside_a[D][DSW-1:1];
        end
    end

    // Horner polynomial
    logic signed [WI-1:0] inner;
    logic signed [WM-1:0] mid;
    logic signed [WT-1:0] tq;
    logic [WX+SIDE_W-1:0] s1, s2;
    logic [SIDE_W-1:0]    s3;

    rtd_mul #(.F(F), .WA(WX), .WB(WC), .WR(WI), .WS(WX+SIDE_W)) u_mul_c (
        .clk    (clk),
        .en     (adv[S_M1+2:S_M1]),
        .a      (x_reg),
        .b      (COEF_C),
        .addend (COEF_B),
        .side_i ({x_reg, sidex_reg}),
        .r      (inner),
        .side_o (s1)
    );

    rtd_mul #(.F(F), .WA(WX), .WB(WI), .WR(WM), .WS(WX+SIDE_W)) u_mul_b (
        .clk    (clk),
        .en     (adv[S_M2+2:S_M2]),
        .a      (signed'(s1[WX+SIDE_W-1:SIDE_W])),
        .b      (inner),
        .addend (COEF_A),
        .side_i (s1),
        .r      (mid),
        .side_o (s2)
    );

    rtd_mul #(.F(F), .WA(WX), .WB(WM), .WR(WT), .WS(SIDE_W)) u_mul_a (
        .clk    (clk),
        .en     (adv[S_M3+2:S_M3]),
        .a      (signed'(s2[WX+SIDE_W-1:SIDE_W])),
        .b      (mid),
        .addend ('0),
        .side_i (s2[SIDE_W-1:0]),
        .r      (tq),
        .side_o (s3)
    );

    // output stage: saturate
    logic [TEMP_W-1:0] temp_next, temp_reg;
    logic [CODE_W-1:0] ocode_reg;
    logic              oovf_reg, orng_reg;

    always_comb
    begin
        if (s3[0] || tq[WT-1])
            temp_next = '0;
        else if (tq[WT-2:F] > (WT-1-F)'(TEMP_MAX))
            temp_next = TEMP_MAX;
        else
            temp_next = tq[F+TEMP_W-1:F];
    end

    always_ff @(posedge clk)
    begin
        if (adv[S_OUT])
        begin
            temp_reg  <= temp_next;
            ocode_reg <= s3[SIDE_W-1:2];
            oovf_reg  <= s3[1];
            orng_reg  <= s3[0];
        end
    end

    assign result_out.valid       = v_reg[S_OUT];
    assign result_out.code        = ocode_reg;
    assign result_out.overflow    = oovf_reg;
    assign result_out.range_error = orng_reg;
    assign result_out.temperature = temp_reg;

    a_rng_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.range_error |-> result_out.temperature == '0)
        else $error("range error with nonzero temperature");

    a_ovf_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.overflow |-> result_out.code == CODE_W'(1))
        else $error("double overflow without code one");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NS-1] |-> sample_in.ready)
        else $error("not ready with empty output stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.ready && v_reg[NS-2] |=> result_out.valid)
        else $error("request lost before output stage");

endmodule
`default_nettype wire
